/* rtl/lcd_nibble_queue_i2c_expander_assert.svh */
// Assertion macros for the LCD nibble queue block.
// Included by the top level; needs nothing else.
`ifndef LCD_NIBBLE_QUEUE_I2C_EXPANDER_ASSERT_SVH
`define LCD_NIBBLE_QUEUE_I2C_EXPANDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LNQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LNQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lnq_pkg.sv */
// Shared types, constants and the microcode table of the LCD nibble queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lnq_pkg;

   // Beat field widths
   localparam int ACTION_W = 3;
   localparam int BYTE_W   = 8;
   localparam int NIB_W    = 4;
   localparam int ENTRY_W  = 5;    // data mark + nibble
   localparam int PC_W     = 5;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_CMD      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CHAR     = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_STROBE_H = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_STROBE_L = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CURSOR   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_INIT     = 3'd5;

   // Expander byte bits and LCD command bytes
   localparam logic [BYTE_W-1:0] MASK_EN_OFF  = 8'b11111011;
   localparam logic [BYTE_W-1:0] BITS_BL_EN   = 8'b00001100;
   localparam logic [BYTE_W-1:0] BITS_BL_EN_RS = 8'b00001101;
   localparam logic [BYTE_W-1:0] INIT_BYTE    = 8'h00;
   localparam logic [BYTE_W-1:0] ROW0_CMD     = 8'b10000000;
   localparam logic [BYTE_W-1:0] ROW1_CMD     = 8'b11000000;
   localparam int                COLUMNS      = 16;

   // Microcode
   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUSH,
      OP_LOOP,
      OP_STROBE_HI,
      OP_LOAD,
      OP_STROBE_LO,
      OP_CLEAR
   } ucode_op_type;

   typedef enum logic [1:0] {
      NIB_OPR_HI,
      NIB_OPR_LO,
      NIB_CONST
   } nib_src_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_LOOP_DONE,
      COND_NO_SEND
   } ucode_cond_type;

   typedef struct packed {
      ucode_op_type   op;
      nib_src_type    src;
      logic [NIB_W-1:0] konst;
      logic           set_run;
      ucode_cond_type cond;
      logic [PC_W-1:0] target;
      logic           last;
   } ucode_word_type;

   // Program addresses
   localparam logic [PC_W-1:0] PC_BYTE   = 5'd0;
   localparam logic [PC_W-1:0] PC_CURSOR = 5'd2;
   localparam logic [PC_W-1:0] PC_LOOP   = 5'd4;
   localparam logic [PC_W-1:0] PC_DONE   = 5'd7;
   localparam logic [PC_W-1:0] PC_SHI    = 5'd8;
   localparam logic [PC_W-1:0] PC_SLO    = 5'd10;
   localparam logic [PC_W-1:0] PC_INIT   = 5'd11;

   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_word_type w;
      w = '{OP_NOP, NIB_CONST, 4'h0, 1'b0, COND_NEXT, PC_DONE, 1'b1};
      unique case (addr)
         // command or character byte: high then low nibble
         5'd0:  w = '{OP_PUSH, NIB_OPR_HI, 4'h0, 1'b0, COND_NEXT, PC_DONE, 1'b0};
         5'd1:  w = '{OP_PUSH, NIB_OPR_LO, 4'h0, 1'b1, COND_NEXT, PC_DONE, 1'b1};
         // set cursor: row command, then cursor-right per column
         5'd2:  w = '{OP_PUSH, NIB_OPR_HI, 4'h0, 1'b0, COND_NEXT, PC_DONE, 1'b0};
         5'd3:  w = '{OP_PUSH, NIB_OPR_LO, 4'h0, 1'b1, COND_NEXT, PC_DONE, 1'b0};
         5'd4:  w = '{OP_LOOP, NIB_CONST, 4'h0, 1'b0, COND_LOOP_DONE, PC_DONE, 1'b0};
         5'd5:  w = '{OP_PUSH, NIB_CONST, 4'h1, 1'b0, COND_NEXT, PC_DONE, 1'b0};
         5'd6:  w = '{OP_PUSH, NIB_CONST, 4'h4, 1'b1, COND_ALWAYS, PC_LOOP, 1'b0};
         // common exit
         5'd7:  w = '{OP_NOP, NIB_CONST, 4'h0, 1'b0, COND_NEXT, PC_DONE, 1'b1};
         // strobe high: check, read queue, build byte
         5'd8:  w = '{OP_STROBE_HI, NIB_CONST, 4'h0, 1'b0, COND_NO_SEND, PC_DONE, 1'b0};
         5'd9:  w = '{OP_LOAD, NIB_CONST, 4'h0, 1'b0, COND_NEXT, PC_DONE, 1'b1};
         // strobe low
         5'd10: w = '{OP_STROBE_LO, NIB_CONST, 4'h0, 1'b0, COND_NEXT, PC_DONE, 1'b1};
         // init: clear, 0x2, 0x28, 0x0F, 0x01
         5'd11: w = '{OP_CLEAR, NIB_CONST, 4'h0, 1'b0, COND_NEXT, PC_DONE, 1'b0};
         5'd12: w = '{OP_PUSH, NIB_CONST, 4'h2, 1'b0, COND_NEXT, PC_DONE, 1'b0};
         5'd13: w = '{OP_PUSH, NIB_CONST, 4'h2, 1'b0, COND_NEXT, PC_DONE, 1'b0};
         5'd14: w = '{OP_PUSH, NIB_CONST, 4'h8, 1'b1, COND_NEXT, PC_DONE, 1'b0};
         5'd15: w = '{OP_PUSH, NIB_CONST, 4'h0, 1'b0, COND_NEXT, PC_DONE, 1'b0};
         5'd16: w = '{OP_PUSH, NIB_CONST, 4'hF, 1'b1, COND_NEXT, PC_DONE, 1'b0};
         5'd17: w = '{OP_PUSH, NIB_CONST, 4'h0, 1'b0, COND_NEXT, PC_DONE, 1'b0};
         5'd18: w = '{OP_PUSH, NIB_CONST, 4'h1, 1'b1, COND_NEXT, PC_DONE, 1'b1};
         default: w = '{OP_NOP, NIB_CONST, 4'h0, 1'b0, COND_NEXT, PC_DONE, 1'b1};
      endcase
      return w;
   endfunction

   // Program entry for each action; unused codes go straight to the exit
   function automatic logic [PC_W-1:0] entry_of(input logic [ACTION_W-1:0] action);
      logic [PC_W-1:0] pc;
      pc = PC_DONE;
      unique case (action)
         ACT_CMD, ACT_CHAR: pc = PC_BYTE;
         ACT_STROBE_H:      pc = PC_SHI;
         ACT_STROBE_L:      pc = PC_SLO;
         ACT_CURSOR:        pc = PC_CURSOR;
         ACT_INIT:          pc = PC_INIT;
         default:           pc = PC_DONE;
      endcase
      return pc;
   endfunction

endpackage

`default_nettype wire

/* rtl/lnq_channels.sv */
// Valid/ready channel interfaces for request and response beats.
// Depends on lnq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lnq_req_if
   import lnq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   value;
   logic                row;
   logic [BYTE_W-1:0]   column;

   modport source (output valid, action, value, row, column, input ready);
   modport sink   (input valid, action, value, row, column, output ready);
endinterface

interface lnq_rsp_if
   import lnq_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              write_valid;
   logic [BYTE_W-1:0] expander_byte;
   logic              busy_res;
   logic              dropped;

   modport source (output valid, write_valid, expander_byte, busy_res, dropped,
                   input ready);
   modport sink   (input valid, write_valid, expander_byte, busy_res, dropped,
                   output ready);
endinterface

`default_nettype wire

/* rtl/lnq_queue_ram.sv */
// Nibble queue storage: one write port, one registered read port.
// Depends on lnq_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none

module lnq_queue_ram
   import lnq_pkg::*;
#(
   parameter int  DEPTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [ENTRY_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output logic      [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/lcd_nibble_queue_i2c_expander.sv */
// Top level of the 4-bit LCD driver over an I2C port expander.
// Depends on lnq_pkg, lnq_channels, lnq_queue_ram and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "lcd_nibble_queue_i2c_expander_assert.svh"

// Each request beat runs a short microcode program (one step per clock) that
// queues nibbles, sends the next queued nibble or drops EN on the last byte,
// and then yields exactly one response beat. The queue has one write port, so
// at most one nibble is queued per step. A new request is taken once the
// previous program has handed its result to the output register; that result
// may still be waiting there. There is no clearing pass: queue entries are
// read only below the fill count.
module lcd_nibble_queue_i2c_expander
   import lnq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   lnq_req_if.sink   req_chan,
   lnq_rsp_if.source rsp_chan
);

   localparam int AW    = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMIT} state_type;

   state_type          state_ff, state_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [BYTE_W-1:0]  opr_ff, opr_in;
   logic               mark_ff, mark_in;
   logic [NIB_W-1:0]   loop_ff, loop_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   send_ff, send_in;
   logic [BYTE_W-1:0]  last_byte_ff, last_byte_in;
   logic               running_ff, running_in;
   logic               drop_ff, drop_in;
   logic               wrote_ff, wrote_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_wv_ff, rsp_wv_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_busy_ff, rsp_busy_in;
   logic               rsp_drop_ff, rsp_drop_in;

   ucode_word_type     cw;
   logic               no_send;
   logic               take_jump;
   logic [NIB_W-1:0]   push_nib;
   logic               wr_en;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic [BYTE_W-1:0]  en_off_byte;
   logic [BYTE_W-1:0]  sent_byte;

   lnq_queue_ram #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({(cw.src != NIB_CONST) & mark_ff, push_nib}),
      .rd_en   (rd_en),
      .rd_addr (send_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // current control word and datapath terms
   assign cw          = ucode_rom(pc_ff);
   assign no_send     = !running_ff || (send_ff >= count_ff);
   assign en_off_byte = last_byte_ff & MASK_EN_OFF;
   assign sent_byte   = {rd_data[NIB_W-1:0],
                         rd_data[ENTRY_W-1] ? BITS_BL_EN_RS[NIB_W-1:0]
                                            : BITS_BL_EN[NIB_W-1:0]};

   always_comb begin
      unique case (cw.src)
         NIB_OPR_HI: push_nib = opr_ff[BYTE_W-1:NIB_W];
         NIB_OPR_LO: push_nib = opr_ff[NIB_W-1:0];
         default:    push_nib = cw.konst;
      endcase
   end

   always_comb begin
      unique case (cw.cond)
         COND_ALWAYS:    take_jump = 1'b1;
         COND_LOOP_DONE: take_jump = (loop_ff == '0);
         COND_NO_SEND:   take_jump = no_send;
         default:        take_jump = 1'b0;
      endcase
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.write_valid   = rsp_wv_ff;
   assign rsp_chan.expander_byte = rsp_byte_ff;
   assign rsp_chan.busy_res      = rsp_busy_ff;
   assign rsp_chan.dropped       = rsp_drop_ff;

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      opr_in       = opr_ff;
      mark_in      = mark_ff;
      loop_in      = loop_ff;
      count_in     = count_ff;
      send_in      = send_ff;
      last_byte_in = last_byte_ff;
      running_in   = running_ff;
      drop_in      = drop_ff;
      wrote_in     = wrote_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_wv_in    = rsp_wv_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_busy_in  = rsp_busy_ff;
      rsp_drop_in  = rsp_drop_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               state_in = S_RUN;
               pc_in    = entry_of(req_chan.action);
               opr_in   = (req_chan.action == ACT_CURSOR)
                        ? (req_chan.row ? ROW1_CMD : ROW0_CMD)
                        : req_chan.value;
               mark_in  = (req_chan.action == ACT_CHAR);
               loop_in  = NIB_W'(req_chan.column % COLUMNS);
               drop_in  = 1'b0;
               wrote_in = 1'b0;
               byte_in  = '0;
            end
         end
         S_RUN: begin
            unique case (cw.op)
               OP_PUSH: begin
                  if (count_ff < CNT_FULL) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     drop_in = 1'b1;
                  end
               end
               OP_LOOP: begin
                  if (loop_ff != '0) begin
                     loop_in = loop_ff - 1'b1;
                  end
               end
               OP_STROBE_HI: begin
                  if (running_ff) begin
                     if (no_send) begin
                        running_in = 1'b0;
                        count_in   = '0;
                        send_in    = '0;
                     end else begin
                        rd_en = 1'b1;
                     end
                  end
               end
               OP_LOAD: begin
                  last_byte_in = sent_byte;
                  byte_in      = sent_byte;
                  wrote_in     = 1'b1;
                  send_in      = send_ff + 1'b1;
               end
               OP_STROBE_LO: begin
                  if (running_ff) begin
                     last_byte_in = en_off_byte;
                     byte_in      = en_off_byte;
                     wrote_in     = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
                  send_in  = '0;
                  wrote_in = 1'b1;
                  byte_in  = INIT_BYTE;
               end
               default: begin
               end
            endcase
            if (cw.set_run) begin
               running_in = 1'b1;
            end
            pc_in = take_jump ? cw.target : pc_ff + 1'b1;
            if (cw.last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_wv_in    = wrote_ff;
               rsp_byte_in  = byte_ff;
               rsp_busy_in  = (send_ff < count_ff);
               rsp_drop_in  = drop_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= PC_DONE;
         count_ff     <= '0;
         send_ff      <= '0;
         last_byte_ff <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         count_ff     <= count_in;
         send_ff      <= send_in;
         last_byte_ff <= last_byte_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      opr_ff      <= opr_in;
      mark_ff     <= mark_in;
      loop_ff     <= loop_in;
      drop_ff     <= drop_in;
      wrote_ff    <= wrote_in;
      byte_ff     <= byte_in;
      rsp_wv_ff   <= rsp_wv_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_busy_ff <= rsp_busy_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   // checks
   `LNQ_ASSERT_NOW(a_send_within_count, clock, reset, 1'b1, send_ff <= count_ff && count_ff <= CNT_FULL, "send index or fill count out of range")
   `LNQ_ASSERT_NEXT(a_accept_starts_program, clock, reset, req_chan.valid && req_chan.ready, state_ff == S_RUN, "accepted beat did not start a program")
   `LNQ_ASSERT_NOW(a_load_after_read, clock, reset, state_ff == S_RUN && cw.op == OP_LOAD, $past(cw.op) == OP_STROBE_HI && $past(rd_en), "byte built without a queue read")
   `LNQ_ASSERT_NOW(a_backlight_on_write, clock, reset, rsp_valid_ff && rsp_wv_ff && rsp_byte_ff != INIT_BYTE, rsp_byte_ff[3], "expander write without backlight")

endmodule

`default_nettype wire
